// ===== rtl/core/ibk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ibk_pkg;

  localparam int unsigned CountW = 4;
  localparam int unsigned LimitW = 4;
  localparam int unsigned AddrW = 1;
  localparam int unsigned DataW = 32;

  localparam logic [AddrW-1:0] RegOverlapLimit = 1'b0;
  localparam logic [LimitW-1:0] LimitReset = 4'd2;

  typedef logic [CountW-1:0] count_t;

endpackage
`default_nettype wire

// ===== rtl/core/ibk_cover_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ibk_cover_mem #(
  parameter int unsigned SLOT_BITS = 10
) (
  input  wire                  clk_i,
  input  wire                  we_i,
  input  wire [SLOT_BITS-1:0]  waddr_i,
  input  wire ibk_pkg::count_t wdata_i,
  input  wire                  re_i,
  input  wire [SLOT_BITS-1:0]  raddr_i,
  output ibk_pkg::count_t      rdata_o
);

  localparam int unsigned Depth = 1 << SLOT_BITS;

  ibk_pkg::count_t mem_q [Depth];
  ibk_pkg::count_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/interval_booking_admission_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Interval admission over 2**SLOT_BITS slots. Each slot keeps its coverage count in a
// single-port-write, registered-read memory; one compare/increment unit walks the slots
// of the requested half-open interval, first checking every slot against overlap_limit,
// then, if all are below it, incrementing each one. Each slot passes through a read
// state and then a compare or write state, paced by the registered memory read; a
// rejected request stops at the first full slot, an empty one is accepted from idle.
// After reset a clearing pass zeroes every slot before the first transfer is taken.
module interval_booking_admission_top #(
  parameter int unsigned SLOT_BITS = 10
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // [SLOT_BITS-1:0] start_slot, [2*SLOT_BITS:SLOT_BITS] end_slot, zero pad
  input  wire [((2 * SLOT_BITS + 1 + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // [0] accepted, zero pad
  output logic [7:0]                   m_axis_tdata,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [ibk_pkg::AddrW-1:0]     paddr,
  input  wire [ibk_pkg::DataW-1:0]     pwdata,
  output logic [ibk_pkg::DataW-1:0]    prdata,
  output logic                         pready
);

  localparam int unsigned CurW = SLOT_BITS + 1;
  localparam logic [CurW-1:0] SlotCount = CurW'(1) << SLOT_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_CHK_RD, ST_CHK_CMP, ST_UPD_RD, ST_UPD_WR
  } state_e;

  state_e state_q;
  logic [CurW-1:0] cur_q, start_q, end_q;
  logic [ibk_pkg::LimitW-1:0] limit_q;
  logic out_valid_q, out_acc_q;

  logic [SLOT_BITS-1:0] in_start;
  logic [CurW-1:0] in_end, end_clip, cur_inc;
  logic in_fire, cfg_wr, mem_we, mem_re;
  ibk_pkg::count_t mem_wdata, mem_rdata;

  assign in_start = s_axis_tdata[SLOT_BITS-1:0];
  assign in_end   = s_axis_tdata[2*SLOT_BITS:SLOT_BITS];
  assign end_clip = (in_end > SlotCount) ? SlotCount : in_end;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign cur_inc  = cur_q + CurW'(1);

  assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_acc_q};

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ibk_pkg::RegOverlapLimit);
  assign prdata = (paddr == ibk_pkg::RegOverlapLimit) ?
                  {{(ibk_pkg::DataW-ibk_pkg::LimitW){1'b0}}, limit_q} : '0;

  assign mem_re    = (state_q == ST_CHK_RD) || (state_q == ST_UPD_RD);
  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_UPD_WR);
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : mem_rdata + ibk_pkg::count_t'(1);

  ibk_cover_mem #(.SLOT_BITS(SLOT_BITS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cur_q[SLOT_BITS-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (cur_q[SLOT_BITS-1:0]),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ibk_pkg::LimitReset;
    end else if (cfg_wr) begin
      limit_q <= pwdata[ibk_pkg::LimitW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cur_q       <= '0;
      start_q     <= '0;
      end_q       <= '0;
      out_valid_q <= 1'b0;
      out_acc_q   <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          cur_q <= cur_inc;
          if (cur_inc == SlotCount) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            if ({1'b0, in_start} >= end_clip) begin
              out_valid_q <= 1'b1;
              out_acc_q   <= 1'b1;
            end else begin
              start_q <= {1'b0, in_start};
              cur_q   <= {1'b0, in_start};
              end_q   <= end_clip;
              state_q <= ST_CHK_RD;
            end
          end
        end
        ST_CHK_RD: begin
          state_q <= ST_CHK_CMP;
        end
        ST_CHK_CMP: begin
          if (mem_rdata >= limit_q) begin
            out_valid_q <= 1'b1;
            out_acc_q   <= 1'b0;
            state_q     <= ST_IDLE;
          end else if (cur_inc == end_q) begin
            cur_q   <= start_q;
            state_q <= ST_UPD_RD;
          end else begin
            cur_q   <= cur_inc;
            state_q <= ST_CHK_RD;
          end
        end
        ST_UPD_RD: begin
          state_q <= ST_UPD_WR;
        end
        ST_UPD_WR: begin
          cur_q <= cur_inc;
          if (cur_inc == end_q) begin
            out_valid_q <= 1'b1;
            out_acc_q   <= 1'b1;
            state_q     <= ST_IDLE;
          end else begin
            state_q <= ST_UPD_RD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // a result appears only out of an idle accept or the end of a walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_IDLE || $past(state_q) == ST_CHK_CMP ||
                            $past(state_q) == ST_UPD_WR))
    else $error("result without finished request");

  // in the read states the walk cursor stays inside the requested interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK_RD || state_q == ST_UPD_RD) |-> (cur_q >= start_q && cur_q < end_q))
    else $error("cursor outside interval");

  // a rejected request never reaches the update phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK_CMP && mem_rdata >= limit_q) |=> state_q == ST_IDLE)
    else $error("update after full slot");

endmodule
`default_nettype wire
